### hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the coordinate set table
// Entry layout, status codes and the memory control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  localparam int CAPACITY_DEF = 512;
  localparam int COORD_W      = 8;
  localparam int KEY_W        = 2 * COORD_W;
  localparam int ENTRY_W      = KEY_W + 1;
  localparam int COUNT_W      = 10;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

### hdl/cst_mem.sv
// ----------------------------------------------------------------------------
// cst_mem: entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cst_mem
  import cst_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire mem_ctl_t           ctl,
  input  wire logic [AW-1:0]      rd_addr,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/cst_ctrl.sv
// ----------------------------------------------------------------------------
// cst_ctrl: request sequencer and key comparator
// Scans the store one entry a cycle, then appends, swaps in the last
// entry, or reports a refusal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cst_ctrl
  import cst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [COORD_W-1:0] in_x,
  input  wire logic [COORD_W-1:0] in_y,
  input  wire logic               in_color,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output status_t                 out_status,
  output logic      [CW-1:0]      out_count,
  output mem_ctl_t                mem_ctl,
  output logic      [AW-1:0]      rd_addr,
  output logic      [AW-1:0]      wr_addr,
  output logic      [ENTRY_W-1:0] wr_data,
  input  wire logic [ENTRY_W-1:0] rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_REPORT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic               op;
  logic [KEY_W-1:0]   key;
  logic               color;
  logic [CW-1:0]      issue_idx;
  logic               pend_valid;
  logic [AW-1:0]      pend_idx;
  logic [AW-1:0]      slot;
  status_t            res_status;

  logic               accept;
  logic               issue_more;
  logic               hit;
  logic               last;
  logic [CW-1:0]      count_m1;
  logic               full;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign count_m1   = count - CW'(1);
  assign full       = (count >= CW'(CAPACITY));
  assign issue_more = (issue_idx < count);
  assign hit        = pend_valid && (rd_data[KEY_W-1:0] == key);
  assign last       = pend_valid && (pend_idx == count_m1[AW-1:0]);

  always_comb begin
    mem_ctl = '0;
    rd_addr = issue_idx[AW-1:0];
    wr_addr = count[AW-1:0];
    wr_data = {color, key};
    unique case (state)
      S_IDLE: begin
        // empty table: append straight away
        mem_ctl.wr_en = accept && !in_op && (count == '0);
        wr_addr       = '0;
        wr_data       = {in_color, in_y, in_x};
      end
      S_SCAN: begin
        mem_ctl.rd_en = issue_more;
        mem_ctl.wr_en = last && !hit && !op;
      end
      S_MOVE_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = count_m1[AW-1:0];
      end
      S_MOVE_WR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = slot;
        wr_data       = rd_data;
      end
      S_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      issue_idx  <= '0;
    end else begin
      pend_valid <= (state == S_SCAN) && issue_more;
      pend_idx   <= issue_idx[AW-1:0];
      if (mem_ctl.rd_en && (state == S_SCAN)) begin
        issue_idx <= issue_idx + CW'(1);
      end
      if (out_valid && out_ready && (state != S_REPORT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= in_op;
            key       <= {in_y, in_x};
            color     <= in_color;
            issue_idx <= '0;
            if (!in_op && full) begin
              res_status <= ST_FULL;
              state      <= S_REPORT;
            end else if (count == '0) begin
              if (!in_op) begin
                count      <= CW'(1);
                res_status <= ST_DONE;
              end else begin
                res_status <= ST_MISS;
              end
              state <= S_REPORT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (!op) begin
              res_status <= ST_DUP;
              state      <= S_REPORT;
            end else if (last) begin
              // last entry simply drops out
              count      <= count_m1;
              res_status <= ST_DONE;
              state      <= S_REPORT;
            end else begin
              slot  <= pend_idx;
              state <= S_MOVE_RD;
            end
          end else if (last) begin
            if (!op) begin
              count      <= count + CW'(1);
              res_status <= ST_DONE;
            end else begin
              res_status <= ST_MISS;
            end
            state <= S_REPORT;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          count      <= count_m1;
          res_status <= ST_DONE;
          state      <= S_REPORT;
        end
        S_REPORT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_count  <= count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1))))
    else $error("entry count moved by more than one");

  a_report_load: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REPORT) && (!out_valid || out_ready)) |=>
      (out_valid && (state == S_IDLE)))
    else $error("result not loaded into output register");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.wr_en && (state == S_SCAN)) |-> !full)
    else $error("append issued on a full table");

endmodule

`default_nettype wire

### hdl/coordinate_set_table.sv
// ----------------------------------------------------------------------------
// coordinate_set_table: fixed-capacity unordered set of coordinate entries
// Add refuses when full or on duplicate coordinates; delete swaps the last
// entry into the freed slot.
//
//   channel  dir  fields
//   s_*      in   tuser: op; tdata: pos_x, pos_y, stone_color
//   m_*      out  tdata: status, entry_count
//
// A request scans the store until it hits or reaches the last entry (one read of
// the store per cycle through the shared key comparator); a delete that hits
// before the last entry then reads the last entry and writes it into the freed
// slot. Add to a full or an empty table and delete from an empty one skip the
// scan and go straight to the report.
// Reset clears the count; the store needs no clearing pass.
// s_tready is low while a request is in work; a stalled result waits in the
// output register while the next beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coordinate_set_table
  import cst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // pos_x[7:0], pos_y[15:8], stone_color[16], zero
  input  wire logic        s_tuser,  // op[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata   // status[1:0], entry_count[11:2], zero
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  status_t            out_status;
  logic [CW-1:0]      out_count;
  logic [CW+COUNT_W-1:0] count_ext;

  cst_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser),
    .in_x       (s_tdata[7:0]),
    .in_y       (s_tdata[15:8]),
    .in_color   (s_tdata[16]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_count  (out_count),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  cst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // count reported modulo the field width
  assign count_ext = {{COUNT_W{1'b0}}, out_count};
  assign m_tdata   = {4'b0000, count_ext[COUNT_W-1:0], out_status};

endmodule

`default_nettype wire
